FILE: hdl/cceq_pkg.sv
// Package for the click-chord event queue.
// Holds the queue and encoder sizes, command and click codes, and the entry type.
// No dependencies.
package cceq_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int ENCODER_COUNT = 2;
    localparam int PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int ENC_W         = $clog2(ENCODER_COUNT);

    localparam logic [1:0] CMD_EVENT = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_POP   = 2'd2;

    localparam logic [2:0] KIND_NONE         = 3'd0;
    localparam logic [2:0] KIND_DOUBLE       = 3'd2;
    localparam logic [2:0] KIND_CHORD_SINGLE = 3'd3;
    localparam logic [2:0] KIND_CHORD_DOUBLE = 3'd4;

    localparam logic [7:0]  CHORD_SOURCE   = 8'hFE;
    localparam logic [15:0] WINDOW_RESET   = 16'd300;
    localparam logic [2:0]  ADDR_WINDOW    = 3'd0;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [2:0]  click_kind;
        logic [15:0] rotation;
        logic [7:0]  source_id;
    } t_entry;

    typedef logic [PTR_W-1:0] t_ptr;

    // Ring successor; also correct for depths that are not a power of two.
    function automatic t_ptr next_slot(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

endpackage

FILE: hdl/click_chord_event_queue_top.sv
// Click-chord event queue: input register, single-pass update, result register.
// Depends on cceq_pkg.
//
// Channel   | Direction | Handshake                     | Carries
// s_axis    | in        | tvalid/tready                 | command in tuser, event in tdata
// m_axis    | out       | tvalid/tready                 | pop result, found flag in tuser
// apb       | in        | psel/penable/pwrite, pready=1 | chord window register
//
// One request per cycle is taken while no pop is stalled; its state update is committed in a single
// pass from the input register to the queue and markers, when the request leaves the input register.
// A pop result is loaded into the output register together with that update.
// Reset is synchronous and active low; it empties the queue, clears markers and
// sets the window to 300 ms. A pop waits in the input register only while the
// result register is full and not being taken, and nothing is accepted behind it.
module click_chord_event_queue_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [7:0] source_id, [23:8] rotation, [26:24] click_kind, [58:27] time_ms
    input  logic [63:0]           s_axis_tdata,
    // [1:0] command
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] out_source_id, [23:8] out_rotation, [26:24] out_click_kind,
    // [58:27] out_time_ms
    output logic [63:0]           m_axis_tdata,
    // [0] valid_res
    output logic [0:0]            m_axis_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import cceq_pkg::*;

    logic                r_in_valid;
    logic [1:0]          r_in_cmd;
    t_entry              r_in_entry;

    t_entry              r_store [QUEUE_DEPTH];
    t_ptr                r_rd;
    t_ptr                r_wr;
    t_ptr                n_rd;
    t_ptr                n_wr;
    logic [2:0]          r_mk [ENCODER_COUNT];
    logic [31:0]         r_mt [ENCODER_COUNT];
    logic [2:0]          n_mk [ENCODER_COUNT];
    logic [31:0]         n_mt [ENCODER_COUNT];
    logic [15:0]         r_window;

    logic                r_out_valid;
    logic                r_out_found;
    t_entry              r_out_entry;
    logic                n_out_found;
    t_entry              n_out_entry;

    logic                w_proceed;
    logic                w_we_a;
    logic                w_we_b;
    t_ptr                w_wr1;
    t_entry              w_chord;
    logic                w_in_range;
    logic [ENC_W-1:0]    w_cur;
    logic [ENC_W-1:0]    w_oth;
    logic [31:0]         w_gap;
    logic [31:0]         w_tick_age [ENCODER_COUNT];
    logic                w_cfg_write;

    assign w_proceed = r_in_valid && (r_in_cmd != CMD_POP || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_entry <= s_axis_tdata[58:0];
        end
    end

    // Chord partner is the next encoder round the ring.
    assign w_in_range = r_in_entry.source_id < 8'(ENCODER_COUNT);
    assign w_cur      = r_in_entry.source_id[ENC_W-1:0];
    assign w_oth      = (w_cur == ENC_W'(ENCODER_COUNT - 1)) ? '0 : w_cur + ENC_W'(1);
    assign w_gap      = r_in_entry.time_ms - r_mt[w_oth];

    always_comb begin
        for (int i = 0; i < ENCODER_COUNT; i++) begin
            w_tick_age[i] = r_in_entry.time_ms - r_mt[i];
        end
    end

    assign w_wr1 = next_slot(r_wr);

    always_comb begin
        t_ptr rd_a;
        t_ptr wr2;
        logic chord_hit;

        n_rd        = r_rd;
        n_wr        = r_wr;
        n_mk        = r_mk;
        n_mt        = r_mt;
        w_we_a      = 1'b0;
        w_we_b      = 1'b0;
        n_out_found = 1'b0;
        n_out_entry = '0;

        rd_a = (w_wr1 == r_rd) ? next_slot(r_rd) : r_rd;
        wr2  = next_slot(w_wr1);
        chord_hit = r_in_entry.click_kind != KIND_NONE && w_in_range &&
                    r_mk[w_oth] != KIND_NONE && w_gap <= {16'd0, r_window};

        w_chord.source_id  = CHORD_SOURCE;
        w_chord.rotation   = '0;
        w_chord.click_kind = (r_in_entry.click_kind == KIND_DOUBLE &&
                              r_mk[w_oth] == KIND_DOUBLE) ? KIND_CHORD_DOUBLE
                                                          : KIND_CHORD_SINGLE;
        w_chord.time_ms    = (r_in_entry.time_ms > r_mt[w_oth]) ? r_in_entry.time_ms
                                                                : r_mt[w_oth];

        if (w_proceed) begin
            unique case (r_in_cmd)
                CMD_EVENT: begin
                    w_we_a = 1'b1;
                    if (chord_hit) begin
                        // The chord entry follows the event itself in the ring.
                        w_we_b = 1'b1;
                        n_wr   = wr2;
                        n_rd   = (wr2 == rd_a) ? next_slot(rd_a) : rd_a;
                        n_mk[w_oth] = KIND_NONE;
                    end else begin
                        n_wr = w_wr1;
                        n_rd = rd_a;
                        if (r_in_entry.click_kind != KIND_NONE && w_in_range) begin
                            n_mk[w_cur] = r_in_entry.click_kind;
                            n_mt[w_cur] = r_in_entry.time_ms;
                        end
                    end
                end
                CMD_TICK: begin
                    for (int i = 0; i < ENCODER_COUNT; i++) begin
                        if (r_mk[i] != KIND_NONE && w_tick_age[i] > {16'd0, r_window}) begin
                            n_mk[i] = KIND_NONE;
                        end
                    end
                end
                CMD_POP: begin
                    if (r_rd != r_wr) begin
                        n_out_found = 1'b1;
                        n_out_entry = r_store[r_rd];
                        n_rd        = next_slot(r_rd);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_store[r_wr] <= r_in_entry;
        end
        if (w_we_b) begin
            r_store[w_wr1] <= w_chord;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
            for (int i = 0; i < ENCODER_COUNT; i++) begin
                r_mk[i] <= KIND_NONE;
                r_mt[i] <= '0;
            end
        end else begin
            r_rd <= n_rd;
            r_wr <= n_wr;
            r_mk <= n_mk;
            r_mt <= n_mt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed && r_in_cmd == CMD_POP) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && r_in_cmd == CMD_POP) begin
            r_out_found <= n_out_found;
            r_out_entry <= n_out_entry;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_entry};
    assign m_axis_tuser  = r_out_found;

    // Configuration port: only paddr[2] is decoded, so every address with paddr[2] clear reaches the window word.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (w_cfg_write && paddr[2] == ADDR_WINDOW[2]) begin
            r_window <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_WINDOW[2]) ? {16'd0, r_window} : 32'd0;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> r_rd == r_wr)
        else $error("queue not empty after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_proceed |=> r_in_valid && $stable(r_in_cmd) && $stable(r_in_entry))
        else $error("stalled request lost");

    a_pop_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proceed && r_in_cmd == CMD_POP && r_rd != r_wr |=> r_rd != $past(r_rd))
        else $error("pop did not advance read pointer");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("empty pop result not zero");

endmodule
